// ===== design/otis_pkg.sv =====
// ============================================================================
// otis_pkg
// Shared types and constants for the ordered table unit: command codes,
// status codes, beat payloads and the command that is broadcast to the cells.
// ============================================================================
package otis_pkg;

   localparam int DEPTH_DEFAULT = 128;

   // Width that holds any cell index, count or position up to the largest table.
   localparam int IDX_CMP_W = 14;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [6:0] found_index;
      logic [7:0] count;
   } rsp_type;

   typedef struct packed {
      logic                 insert_en;
      logic                 delete_en;
      logic                 search_en;
      logic [IDX_CMP_W-1:0] ptr;
      logic [IDX_CMP_W-1:0] used;
      logic signed [31:0]   value;
   } cell_cmd_type;

endpackage

// ===== design/otis_cell.sv =====
// ============================================================================
// otis_cell
// One table slot. Shifts its entry to or from a neighbor on insert and
// delete, loads the new value at the insert point and compares on search.
// ============================================================================
module otis_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  otis_pkg::cell_cmd_type    cmd,
   input  logic signed [31:0]        left_entry,
   input  logic signed [31:0]        right_entry,
   output logic signed [31:0]        entry,
   output logic                      match
);

   localparam logic [otis_pkg::IDX_CMP_W-1:0] MY_IDX = otis_pkg::IDX_CMP_W'(INDEX);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               match_ff;
   logic               match_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert_en) begin
         if (MY_IDX > cmd.ptr) begin
            entry_in = left_entry;
         end else if (MY_IDX == cmd.ptr) begin
            entry_in = cmd.value;
         end
      end else if (cmd.delete_en) begin
         if (MY_IDX >= cmd.ptr) begin
            entry_in = right_entry;
         end
      end
   end

   assign match_in = cmd.search_en && (MY_IDX < cmd.used) && (entry_ff == cmd.value);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.insert_en || cmd.delete_en || cmd.search_en) begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== design/otis_encoder.sv =====
// ============================================================================
// otis_encoder
// Finds the lowest cell that reported a match and encodes its index.
// ============================================================================
module otis_encoder #(
   parameter int DEPTH = otis_pkg::DEPTH_DEFAULT
) (
   input  logic [DEPTH-1:0]         match_vec,
   output logic                     found,
   output logic [$clog2(DEPTH)-1:0] index
);

   localparam int IW = $clog2(DEPTH);

   logic [DEPTH-1:0] onehot;

   // Isolate the lowest set bit with one wide add.
   assign onehot = match_vec & (~match_vec + DEPTH'(1));
   assign found  = |match_vec;

   always_comb begin
      index = '0;
      for (int b = 0; b < IW; b++) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (((i >> b) & 1) == 1) begin
               index[b] = index[b] | onehot[i];
            end
         end
      end
   end

endmodule

// ===== design/ordered_table_insert_delete_search_unit.sv =====
// ============================================================================
// ordered_table_insert_delete_search_unit
// Ordered table of signed 32-bit entries held in a row of cells.
// ============================================================================
// The request channel carries one command per beat: insert a value at a
// 1-based position, delete the entry at a position, or search for a value.
// Each request beat produces exactly one response beat with a status, the
// index of the first match on a successful search and the entry count after
// the command. Errors (full, empty, bad position, not found) leave the table
// unchanged.
// When a command is accepted, every cell shifts, loads or compares at the
// accepting edge, and the lowest matching cell is encoded in the next cycle.
// The response beat passes through the registered match bits of the cells
// and the response register after the priority encoder before it is valid.
// A new request can be accepted every cycle while the response side does
// not stall, so throughput is one command per cycle.
// Reset clears the entry count and empties the pipeline; entry storage is not
// cleared and is only read below the count. While the response side stalls,
// the response register holds its beat and one more command may be taken
// into the encoder stage before req_stall rises.
// ============================================================================
module ordered_table_insert_delete_search_unit #(
   parameter int DEPTH = otis_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  otis_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output otis_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int XW = otis_pkg::IDX_CMP_W;

   logic [CW-1:0]             used_ff;
   logic [CW-1:0]             used_in;
   logic                      s1_valid_ff;
   logic                      s1_search_ff;
   otis_pkg::status_type      s1_status_ff;
   logic [7:0]                s1_count_ff;
   logic                      rsp_valid_ff;
   otis_pkg::rsp_type         rsp_data_ff;
   otis_pkg::rsp_type         rsp_data_in;
   otis_pkg::status_type      status_in;
   otis_pkg::cell_cmd_type    cmd;
   logic                      accept;
   logic                      out_free;
   logic                      s1_free;
   logic [XW-1:0]             pos_x;
   logic [XW-1:0]             used_x;
   logic                      full;
   logic                      empty;
   logic                      ins_bad;
   logic                      del_bad;
   logic signed [31:0]        entry_bus [DEPTH];
   logic [DEPTH-1:0]          match_vec;
   logic                      found;
   logic [IW-1:0]             found_idx;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || out_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   assign pos_x   = XW'(req_data.position);
   assign used_x  = XW'(used_ff);
   assign full    = (used_ff == CW'(DEPTH));
   assign empty   = (used_ff == '0);
   assign ins_bad = (pos_x == '0) || (pos_x > used_x + XW'(1));
   assign del_bad = (pos_x == '0) || (pos_x > used_x);

   always_comb begin
      status_in     = otis_pkg::ST_OK;
      used_in       = used_ff;
      cmd.insert_en = 1'b0;
      cmd.delete_en = 1'b0;
      cmd.search_en = 1'b0;
      cmd.ptr       = pos_x - XW'(1);
      cmd.used      = used_x;
      cmd.value     = req_data.value;
      case (req_data.op)
         otis_pkg::OP_INSERT: begin
            if (full) begin
               status_in = otis_pkg::ST_FULL;
            end else if (ins_bad) begin
               status_in = otis_pkg::ST_BADPOS;
            end else begin
               cmd.insert_en = accept;
               used_in       = used_ff + CW'(1);
            end
         end
         otis_pkg::OP_DELETE: begin
            if (empty) begin
               status_in = otis_pkg::ST_EMPTY;
            end else if (del_bad) begin
               status_in = otis_pkg::ST_BADPOS;
            end else begin
               cmd.delete_en = accept;
               used_in       = used_ff - CW'(1);
            end
         end
         otis_pkg::OP_SEARCH: begin
            cmd.search_en = accept;
         end
         default: begin
            status_in = otis_pkg::ST_OK;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_entry;
      logic signed [31:0] right_entry;
      if (i == 0) begin : g_first
         assign left_entry = req_data.value;
      end else begin : g_mid_l
         assign left_entry = entry_bus[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid_r
         assign right_entry = entry_bus[i+1];
      end
      otis_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_bus[i]),
         .match       (match_vec[i])
      );
   end

   otis_encoder #(
      .DEPTH (DEPTH)
   ) u_encoder (
      .match_vec (match_vec),
      .found     (found),
      .index     (found_idx)
   );

   always_comb begin
      rsp_data_in.count       = s1_count_ff;
      rsp_data_in.status      = s1_status_ff;
      rsp_data_in.found_index = '0;
      if (s1_search_ff) begin
         if (found) begin
            rsp_data_in.status      = otis_pkg::ST_OK;
            rsp_data_in.found_index = 7'(found_idx);
         end else begin
            rsp_data_in.status = otis_pkg::ST_NOTFOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            used_ff <= used_in;
         end
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_search_ff <= (req_data.op == otis_pkg::OP_SEARCH);
         s1_status_ff <= status_in;
         s1_count_ff  <= 8'(used_in);
      end
      if (out_free && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/otis_checker.sv =====
// ============================================================================
// otis_checker
// Port-level checks on the ordered table unit, bound to the top level.
// ============================================================================
module otis_checker #(
   parameter int DEPTH = otis_pkg::DEPTH_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input otis_pkg::rsp_type rsp_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_err_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != otis_pkg::ST_OK) |-> rsp_data.found_index == 7'd0)
      else $error("error response carries a found index");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == otis_pkg::ST_FULL) |-> rsp_data.count == 8'(DEPTH))
      else $error("full status with count below depth");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == otis_pkg::ST_EMPTY) |-> rsp_data.count == 8'd0)
      else $error("empty status with nonzero count");

endmodule

bind ordered_table_insert_delete_search_unit otis_checker #(
   .DEPTH (DEPTH)
) u_otis_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
